>>> rtl/feeder_motor_channel_controller_defines.svh
// assertion macros for the feeder motor channel controller
// no dependencies; included by the top level, which carries the assertions
`ifndef FEEDER_MOTOR_CHANNEL_CONTROLLER_DEFINES_SVH
`define FEEDER_MOTOR_CHANNEL_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define FMCC_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("fmcc check failed");
// next-cycle implication, checked outside reset
`define FMCC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("fmcc check failed");
`else
`define FMCC_ASSERT_NOW(label, clk, rst, cond, prop)
`define FMCC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

>>> rtl/fmcc_pkg.sv
// types and constants for the feeder motor channel controller
// no dependencies; imported by fmcc_core, the top level, the checker and the testbench
package fmcc_pkg;

   // channel count and derived widths
   localparam int CHANNELS = 4;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SW_PAD   = (CHANNELS > 4) ? CHANNELS : 4;
   localparam int ID_W     = 12;

   // frame constants
   localparam logic [15:0] FRAME_HEAD = 16'h2F2F;
   localparam logic [7:0]  BROADCAST  = 8'hFF;

   // frame commands
   localparam logic [7:0]  CMD_STATUS    = 8'd0;
   localparam logic [7:0]  CMD_MOTOR     = 8'd1;
   localparam logic [7:0]  CMD_PARAM_SET = 8'd2;

   // item kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_FRAME = 2'd1;
   localparam logic [1:0] REQ_CLOSE = 2'd2;

   // channel modes
   localparam logic [1:0] MOTOR_STOP = 2'd0;
   localparam logic [1:0] MOTOR_FWD  = 2'd1;
   localparam logic [1:0] MOTOR_REV  = 2'd2;

   // pin pairs: bit0 up pin, bit1 down pin
   localparam logic [1:0] PINS_OFF  = 2'b00;
   localparam logic [1:0] PINS_UP   = 2'b01;
   localparam logic [1:0] PINS_DOWN = 2'b10;

   // register indexes
   localparam logic [1:0] CSR_UNIT_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_HOLD_TICKS   = 2'd1;
   localparam logic [1:0] CSR_SWITCH_LEVEL = 2'd2;

   localparam logic [5:0] UNIT_ADDRESS_RESET = 6'd0;
   localparam logic [3:0] HOLD_TICKS_RESET   = 4'd5;
   localparam logic [3:0] SWITCH_LEVEL_RESET = 4'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] frame_head;
      logic [7:0]  dest_address;
      logic [7:0]  command_code;
      logic [7:0]  motor_number;
      logic [7:0]  direction;
      logic [3:0]  switch_levels;
   } req_word_type;

   typedef struct packed {
      logic [7:0] motor_pins;
      logic [7:0] channel_modes;
      logic       reply_valid;
      logic [5:0] reply_source;
   } rsp_word_type;

   typedef struct packed {
      logic [5:0] unit_address;
      logic [3:0] hold_ticks;
      logic [3:0] switch_active_level;
   } cfg_type;

   typedef struct packed {
      logic [CHANNELS-1:0][1:0] channel_mode;
      logic [CHANNELS-1:0][3:0] hold_count;
      logic [2*CHANNELS-1:0]    pin_levels;
   } chan_state_type;

endpackage

>>> rtl/fmcc_core.sv
// per-item update logic: next channel state and the result word
// depends on fmcc_pkg
module fmcc_core (
   input  fmcc_pkg::req_word_type   word,
   input  fmcc_pkg::cfg_type        cfg,
   input  fmcc_pkg::chan_state_type cur,
   output fmcc_pkg::chan_state_type nxt,
   output fmcc_pkg::rsp_word_type   rsp
);
   import fmcc_pkg::*;

   function automatic logic [1:0] pins_of_mode(input logic [1:0] m);
      logic [1:0] p;
      case (m)
         MOTOR_FWD: p = PINS_DOWN;
         MOTOR_REV: p = PINS_UP;
         default:   p = PINS_OFF;
      endcase
      return p;
   endfunction

   logic [SW_PAD-1:0] sw_pad;
   logic [SW_PAD-1:0] act_pad;
   logic [3:0]        load;
   logic [ID_W-1:0]   base;
   logic [ID_W-1:0]   diff;
   logic [CH_W-1:0]   ch_idx;
   logic              frame_ok;
   logic              reply;

   assign sw_pad  = SW_PAD'(word.switch_levels);
   assign act_pad = SW_PAD'(cfg.switch_active_level);
   assign load    = (cfg.hold_ticks == 4'd0) ? 4'd1 : cfg.hold_ticks;

   // channel offset from the global motor number; negative wraps out of range
   assign base   = ID_W'(cfg.unit_address) * ID_W'(CHANNELS);
   assign diff   = ID_W'(word.motor_number) - base;
   assign ch_idx = diff[CH_W-1:0];

   assign frame_ok = (word.frame_head == FRAME_HEAD)
                  && ((word.dest_address == 8'(cfg.unit_address))
                      || (word.dest_address == BROADCAST))
                  && (word.command_code == CMD_MOTOR)
                  && (diff < ID_W'(CHANNELS));

   // state update by item kind
   always_comb begin
      nxt   = cur;
      reply = 1'b0;
      case (word.mode)
         REQ_TICK: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (cur.channel_mode[i] == MOTOR_REV) begin
                  nxt.pin_levels[2*i +: 2] = sw_pad[i] ? PINS_OFF : PINS_UP;
               end else if (sw_pad[i] == act_pad[i]) begin
                  nxt.hold_count[i]        = load;
                  nxt.pin_levels[2*i +: 2] = PINS_DOWN;
               end else if (cur.hold_count[i] != 4'd0) begin
                  // hold expires: back to the commanded pins
                  if (cur.hold_count[i] == 4'd1) begin
                     nxt.pin_levels[2*i +: 2] = pins_of_mode(cur.channel_mode[i]);
                  end
                  nxt.hold_count[i] = cur.hold_count[i] - 4'd1;
               end
            end
         end
         REQ_FRAME: begin
            if (frame_ok) begin
               reply = 1'b1;
               if (word.direction <= 8'(MOTOR_REV)) begin
                  nxt.channel_mode[ch_idx]      = word.direction[1:0];
                  nxt.pin_levels[2*ch_idx +: 2] = pins_of_mode(word.direction[1:0]);
               end
            end
         end
         REQ_CLOSE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               nxt.channel_mode[i]        = MOTOR_STOP;
               nxt.pin_levels[2*i +: 2]   = PINS_OFF;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // result word from the updated state
   assign rsp.motor_pins    = 8'(nxt.pin_levels);
   assign rsp.channel_modes = 8'(nxt.channel_mode);
   assign rsp.reply_valid   = reply;
   assign rsp.reply_source  = reply ? cfg.unit_address : 6'd0;

endmodule

>>> rtl/feeder_motor_channel_controller.sv
// Four-channel H-bridge feeder controller: takes one word per cycle while
// results are taken (switch tick, command frame or connection close) and
// returns one result word per word with the pins, modes and reply flag after
// that word. A word goes through an input register and then a result register.
// If the result is stalled, one more word waits in the input register before
// req_ready drops. The user must write configuration only while no word is in
// flight; the block itself does not enforce it.
// depends on fmcc_pkg, fmcc_core and the defines header
`include "feeder_motor_channel_controller_defines.svh"
module feeder_motor_channel_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fmcc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fmcc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [5:0]             csr_write_data
);
   import fmcc_pkg::*;

   cfg_type        cfg_ff;
   chan_state_type state_ff;
   chan_state_type state_in;
   req_word_type   in_word_ff;
   logic           in_valid_ff;
   rsp_word_type   rsp_word_ff;
   rsp_word_type   rsp_word_in;
   logic           rsp_valid_ff;
   logic           advance;

   // input stage moves on when the result register is free or being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_address        <= UNIT_ADDRESS_RESET;
         cfg_ff.hold_ticks          <= HOLD_TICKS_RESET;
         cfg_ff.switch_active_level <= SWITCH_LEVEL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_UNIT_ADDRESS: cfg_ff.unit_address        <= csr_write_data;
            CSR_HOLD_TICKS:   cfg_ff.hold_ticks          <= csr_write_data[3:0];
            CSR_SWITCH_LEVEL: cfg_ff.switch_active_level <= csr_write_data[3:0];
            default:          cfg_ff                     <= cfg_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
   end

   fmcc_core u_core (
      .word (in_word_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (rsp_word_in)
   );

   // channel state, committed as the word leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // checks
   `FMCC_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `FMCC_ASSERT_NOW(a_empty_ready, clock, reset, !in_valid_ff, req_ready)
   `FMCC_ASSERT_NOW(a_full_accept, clock, reset, req_valid && req_ready && in_valid_ff, advance)
   `FMCC_ASSERT_NOW(a_reply_src, clock, reset, rsp_valid_ff && !rsp_word_ff.reply_valid, rsp_word_ff.reply_source == 6'd0)

endmodule

>>> verif/feeder_motor_channel_controller_checker.sv
// checker for the feeder motor channel controller: tracks register writes,
// predicts the result word of every accepted request word and compares them
// depends on fmcc_pkg
module feeder_motor_channel_controller_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  fmcc_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  fmcc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [5:0]             csr_write_data,
   output int                     mismatches,
   output int                     words_in_flight
);
   import fmcc_pkg::*;

   // shadow registers
   logic [5:0] unit_address;
   logic [3:0] hold_ticks;
   logic [3:0] active_level;

   // shadow channel state
   logic [1:0]            chan_mode [CHANNELS];
   logic [3:0]            hold_left [CHANNELS];
   logic [2*CHANNELS-1:0] pin_levels;

   rsp_word_type expected_outputs [$];

   // pin pair that a commanded mode drives
   function automatic logic [1:0] pins_for_mode(input logic [1:0] m);
      case (m)
         MOTOR_FWD: return PINS_DOWN;
         MOTOR_REV: return PINS_UP;
         default:   return PINS_OFF;
      endcase
   endfunction

   // advance the shadow state by one request word, return the outputs after it
   function automatic rsp_word_type outputs_after(input req_word_type w);
      rsp_word_type r;
      logic [3:0]   reload;
      logic         lvl;
      logic         act;
      logic         reply;
      int           id;
      reply = 1'b0;
      case (w.mode)
         REQ_TICK: begin
            reload = (hold_ticks == 4'd0) ? 4'd1 : hold_ticks;
            for (int i = 0; i < CHANNELS; i++) begin
               lvl = (i < 4) ? w.switch_levels[i] : 1'b0;
               act = (i < 4) ? active_level[i] : 1'b0;
               if (chan_mode[i] == MOTOR_REV) begin
                  // reversing: the switch at 1 always stops it
                  pin_levels[2*i +: 2] = lvl ? PINS_OFF : PINS_UP;
               end else if (lvl == act) begin
                  hold_left[i] = reload;
                  pin_levels[2*i +: 2] = PINS_DOWN;
               end else if (hold_left[i] != 4'd0) begin
                  // hold expires: back to the commanded pins
                  if (hold_left[i] == 4'd1)
                     pin_levels[2*i +: 2] = pins_for_mode(chan_mode[i]);
                  hold_left[i] = hold_left[i] - 4'd1;
               end
            end
         end
         REQ_FRAME: begin
            if (w.frame_head == FRAME_HEAD && w.command_code == CMD_MOTOR &&
                (w.dest_address == {2'b00, unit_address} ||
                 w.dest_address == BROADCAST)) begin
               id = int'(w.motor_number) - CHANNELS * int'(unit_address);
               if (id >= 0 && id < CHANNELS) begin
                  // unknown direction codes still get a reply
                  if (w.direction <= MOTOR_REV) begin
                     chan_mode[id] = w.direction[1:0];
                     pin_levels[2*id +: 2] = pins_for_mode(w.direction[1:0]);
                  end
                  reply = 1'b1;
               end
            end
         end
         REQ_CLOSE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               chan_mode[i] = MOTOR_STOP;
               pin_levels[2*i +: 2] = PINS_OFF;
            end
         end
         default: ;
      endcase
      r.motor_pins = pin_levels[7:0];
      r.channel_modes = '0;
      for (int i = 0; i < CHANNELS && i < 4; i++)
         r.channel_modes[2*i +: 2] = chan_mode[i];
      r.reply_valid = reply;
      r.reply_source = reply ? unit_address : 6'd0;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         unit_address = UNIT_ADDRESS_RESET;
         hold_ticks = HOLD_TICKS_RESET;
         active_level = SWITCH_LEVEL_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_mode[i] = MOTOR_STOP;
            hold_left[i] = 4'd0;
         end
         pin_levels = '0;
         expected_outputs.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_UNIT_ADDRESS: unit_address = csr_write_data;
               CSR_HOLD_TICKS:   hold_ticks = csr_write_data[3:0];
               CSR_SWITCH_LEVEL: active_level = csr_write_data[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               $error("result word with no request word outstanding");
               mismatches++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("motor_pins", want.motor_pins, rsp_word.motor_pins);
               check_field("channel_modes", want.channel_modes, rsp_word.channel_modes);
               check_field("reply_valid", 8'(want.reply_valid), 8'(rsp_word.reply_valid));
               check_field("reply_source", 8'(want.reply_source), 8'(rsp_word.reply_source));
            end
         end
         if (req_valid && req_ready)
            expected_outputs.push_back(outputs_after(req_word));
      end
      words_in_flight <= expected_outputs.size();
   end

endmodule

>>> verif/feeder_motor_channel_controller_tb.sv
// testbench top for the feeder motor channel controller: clock, reset,
// request words, register writes and the verdict
// depends on fmcc_pkg, the block and feeder_motor_channel_controller_checker
module feeder_motor_channel_controller_tb;
   import fmcc_pkg::*;

   localparam int RUN_LIMIT     = 200000;
   localparam int PHASES        = 7;
   localparam int WORDS_PER_SET = 185;
   localparam int DRAIN_CYCLES  = 4;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable;
   logic [1:0]   csr_index;
   logic [5:0]   csr_write_data;

   logic         steady = 1'b0;
   int           cycle_count;
   int           mismatches;
   int           words_in_flight;
   logic [5:0]   cur_unit;
   logic [3:0]   cur_level;

   // 10 unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   feeder_motor_channel_controller u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   feeder_motor_channel_controller_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .words_in_flight  (words_in_flight)
   );

   // result side stalls about 8 percent of the time, never while steady
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 8);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("feeder_motor_channel_controller_tb: errors");
         $finish;
      end
   end

   // request word with every field random
   function automatic req_word_type noise_word();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(req_word_type)-1:0];
   endfunction

   function automatic req_word_type tick_word(input logic [3:0] levels);
      req_word_type w;
      w = noise_word();
      w.mode = REQ_TICK;
      w.switch_levels = levels;
      return w;
   endfunction

   function automatic req_word_type frame_word(input logic [7:0] dest, input logic [7:0] cmd,
                                               input logic [7:0] motor, input logic [7:0] dir);
      req_word_type w;
      w = noise_word();
      w.mode = REQ_FRAME;
      w.frame_head = FRAME_HEAD;
      w.dest_address = dest;
      w.command_code = cmd;
      w.motor_number = motor;
      w.direction = dir;
      return w;
   endfunction

   // mostly ticks near the active levels and well-formed motor frames
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      logic [3:0]   released;
      logic [7:0]   dest;
      logic [7:0]   cmd;
      logic [7:0]   dir;
      pick = $urandom_range(99);
      dest = $urandom_range(1) ? {2'b00, cur_unit} : BROADCAST;
      dir = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(2));
      if (pick < 45) begin
         // each switch released about seven times in eight
         released = 4'($urandom | $urandom | $urandom);
         w = tick_word(($urandom_range(3) == 0) ? 4'($urandom) : (cur_level ^ released));
      end else if (pick < 93) begin
         w = frame_word(dest, CMD_MOTOR, 8'(CHANNELS * cur_unit + $urandom_range(3)), dir);
         // broken frames
         if (pick >= 85) begin
            case ($urandom_range(3))
               0: w.frame_head = w.frame_head ^ 16'(1 << $urandom_range(15));
               1: begin
                  w.dest_address = 8'($urandom);
                  if (w.dest_address == {2'b00, cur_unit} || w.dest_address == BROADCAST)
                     w.dest_address = {2'b00, cur_unit} + 8'd1;
               end
               2: begin
                  cmd = ($urandom_range(1) == 0) ? CMD_STATUS : 8'($urandom);
                  w.command_code = (cmd == CMD_MOTOR) ? CMD_PARAM_SET : cmd;
               end
               default: w.motor_number = w.motor_number + 8'(4 + $urandom_range(251));
            endcase
         end
      end else if (pick < 96) begin
         w = noise_word();
         w.mode = REQ_CLOSE;
      end else begin
         w = noise_word();
      end
      return w;
   endfunction

   // offer one word and hold it until taken
   task automatic push_word(input req_word_type w);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < 8)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all three registers, spare high bits random
   task automatic load_config(input logic [5:0] unit, input logic [3:0] hold,
                              input logic [3:0] level);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_UNIT_ADDRESS;
      csr_write_data <= unit;
      @(posedge clock);
      csr_index <= CSR_HOLD_TICKS;
      csr_write_data <= {2'($urandom_range(3)), hold};
      @(posedge clock);
      csr_index <= CSR_SWITCH_LEVEL;
      csr_write_data <= {2'($urandom_range(3)), level};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_unit = unit;
      cur_level = level;
   endtask

   initial begin
      req_word_type odd_word;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_UNIT_ADDRESS;
      csr_write_data = '0;
      cur_unit = UNIT_ADDRESS_RESET;
      cur_level = SWITCH_LEVEL_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: commands on every channel, then switch ticks and hold expiry
      push_word(frame_word(8'd0, CMD_MOTOR, 8'd0, 8'(MOTOR_FWD)));
      push_word(frame_word(BROADCAST, CMD_MOTOR, 8'd1, 8'(MOTOR_REV)));
      push_word(frame_word(8'd0, CMD_MOTOR, 8'd2, 8'(MOTOR_FWD)));
      push_word(frame_word(8'd0, CMD_MOTOR, 8'd3, 8'hFF));
      push_word(tick_word(4'b0000));
      push_word(tick_word(4'b1111));
      repeat (6) push_word(tick_word(4'b0000));
      // rejected frames, then an unknown direction code
      odd_word = frame_word(8'd0, CMD_MOTOR, 8'd0, 8'(MOTOR_REV));
      odd_word.frame_head = 16'h2F2E;
      push_word(odd_word);
      odd_word.frame_head = 16'hFFFF;
      push_word(odd_word);
      push_word(frame_word(8'd1, CMD_MOTOR, 8'd0, 8'(MOTOR_REV)));
      push_word(frame_word(8'd0, CMD_STATUS, 8'd0, 8'(MOTOR_REV)));
      push_word(frame_word(8'd0, CMD_PARAM_SET, 8'd0, 8'(MOTOR_REV)));
      push_word(frame_word(BROADCAST, 8'hFF, 8'd0, 8'(MOTOR_REV)));
      push_word(frame_word(8'd0, CMD_MOTOR, 8'd4, 8'(MOTOR_REV)));
      push_word(frame_word(8'd0, CMD_MOTOR, 8'hFF, 8'(MOTOR_REV)));
      push_word(frame_word(8'd0, CMD_MOTOR, 8'd2, 8'd3));
      // command during a hold
      push_word(tick_word(4'b1111));
      push_word(frame_word(8'd0, CMD_MOTOR, 8'd0, 8'(MOTOR_REV)));
      push_word(tick_word(4'b0000));
      // unused mode, then connection close
      odd_word = '1;
      push_word(odd_word);
      odd_word = '0;
      odd_word.mode = REQ_CLOSE;
      push_word(odd_word);

      // random words under several register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1: load_config(6'd63, 4'd15, 4'hF);
               2: load_config(6'd0, 4'd0, 4'h0);
               3: load_config(6'd1, 4'd1, 4'hA);
               default: load_config(6'($urandom_range(63)), 4'($urandom_range(15)),
                                    4'($urandom_range(15)));
            endcase
         end
         steady <= (phase == 4);
         for (int n = 0; n < WORDS_PER_SET; n++) begin
            if (phase == 0 && n == WORDS_PER_SET / 2)
               settle();
            push_word(random_word());
         end
      end

      settle();
      if (mismatches == 0)
         $display("feeder_motor_channel_controller_tb: clean");
      else
         $display("feeder_motor_channel_controller_tb: errors");
      $finish;
   end

endmodule
